// ===== design/r32x_pkg.sv =====
// ----------------------------------------------------------------------------
// r32x_pkg: shared constants for the integer execute core
// Opcodes, flag positions, status codes and reset values.
// ----------------------------------------------------------------------------
package r32x_pkg;

   localparam logic [31:0] PC_RESET  = 32'hffff_fff0;
   localparam logic [31:0] PSW_RESET = 32'h0000_8000;

   localparam int F_Z  = 0;
   localparam int F_S  = 1;
   localparam int F_OV = 2;
   localparam int F_CY = 3;
   localparam int F_ID = 4;
   localparam int F_NP = 5;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_PENDING = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_STRAY   = 2'd3;

   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;

   localparam logic [5:0] OP_MOV    = 6'h00;
   localparam logic [5:0] OP_ADD    = 6'h01;
   localparam logic [5:0] OP_SUB    = 6'h02;
   localparam logic [5:0] OP_CMP    = 6'h03;
   localparam logic [5:0] OP_SHL    = 6'h04;
   localparam logic [5:0] OP_JMP    = 6'h06;
   localparam logic [5:0] OP_OR     = 6'h0c;
   localparam logic [5:0] OP_AND    = 6'h0d;
   localparam logic [5:0] OP_XOR    = 6'h0e;
   localparam logic [5:0] OP_MOVI   = 6'h10;
   localparam logic [5:0] OP_ADDI5  = 6'h11;
   localparam logic [5:0] OP_CMPI   = 6'h13;
   localparam logic [5:0] OP_SHLI   = 6'h14;
   localparam logic [5:0] OP_CLI    = 6'h16;
   localparam logic [5:0] OP_SARI   = 6'h17;
   localparam logic [5:0] OP_RETI   = 6'h19;
   localparam logic [5:0] OP_LDSR   = 6'h1c;
   localparam logic [5:0] OP_SEI    = 6'h1e;
   localparam logic [5:0] OP_MOVEA  = 6'h28;
   localparam logic [5:0] OP_ADDI   = 6'h29;
   localparam logic [5:0] OP_JR     = 6'h2a;
   localparam logic [5:0] OP_JAL    = 6'h2b;
   localparam logic [5:0] OP_ORI    = 6'h2c;
   localparam logic [5:0] OP_ANDI   = 6'h2d;
   localparam logic [5:0] OP_MOVHI  = 6'h2f;
   localparam logic [5:0] OP_LDB    = 6'h30;
   localparam logic [5:0] OP_LDH    = 6'h31;
   localparam logic [5:0] OP_LDW    = 6'h33;
   localparam logic [5:0] OP_STB    = 6'h34;
   localparam logic [5:0] OP_STH    = 6'h35;
   localparam logic [5:0] OP_STW    = 6'h37;

   localparam logic [4:0] SR_EIPC  = 5'd0;
   localparam logic [4:0] SR_EIPSW = 5'd1;
   localparam logic [4:0] SR_FEPC  = 5'd2;
   localparam logic [4:0] SR_FEPSW = 5'd3;
   localparam logic [4:0] SR_PSW   = 5'd5;

   localparam logic [3:0] CC_C  = 4'd1;
   localparam logic [3:0] CC_Z  = 4'd2;
   localparam logic [3:0] CC_NH = 4'd3;
   localparam logic [3:0] CC_N  = 4'd4;
   localparam logic [3:0] CC_T  = 4'd5;
   localparam logic [3:0] CC_LT = 4'd6;
   localparam logic [3:0] CC_LE = 4'd7;
   localparam logic [3:0] CC_NV = 4'd8;
   localparam logic [3:0] CC_NC = 4'd9;
   localparam logic [3:0] CC_NZ = 4'd10;
   localparam logic [3:0] CC_H  = 4'd11;
   localparam logic [3:0] CC_P  = 4'd12;
   localparam logic [3:0] CC_GE = 4'd14;
   localparam logic [3:0] CC_GT = 4'd15;

   function automatic logic [5:0] psw_flags(input logic [31:0] v);
      return {v[15], v[12], v[3:0]};
   endfunction

endpackage

// ===== design/risc32_integer_execute_core_top.sv =====
// ----------------------------------------------------------------------------
// risc32_integer_execute_core_top: integer execute core
// An accepted request beat passes the register file read port stage, then the
// combinational execute logic, into the result register; throughput one beat per
// cycle while rsp_ready does not stall the result register.
// Synchronous reset: pc to fffffff0, NP set, no load pending, pipe empty.
// Register file contents are not reset; r0 always reads zero.
// ----------------------------------------------------------------------------
module risc32_integer_execute_core_top
   import r32x_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_instr_first,
   input  logic [15:0] req_instr_second,
   input  logic [31:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_mem_valid,
   output logic        rsp_mem_write,
   output logic [1:0]  rsp_mem_size,
   output logic [31:0] rsp_mem_addr,
   output logic [31:0] rsp_mem_wdata,
   output logic [3:0]  rsp_cycle_cost,
   output logic [1:0]  rsp_status
);

   logic [31:0] gpr_mem [32];

   logic        s1_valid_ff;
   logic        s1_cmd_ff;
   logic [15:0] s1_ins_ff, s1_ext_ff;
   logic [31:0] s1_lv_ff, s1_a_ff, s1_b_ff;

   logic [31:0] pc_ff, pc_in;
   logic [5:0]  flags_ff, flags_in;
   logic [31:0] eipc_ff, eipc_in, eipsw_ff, eipsw_in, fepc_ff, fepc_in, fepsw_ff, fepsw_in;
   logic        lp_ff, lp_in;
   logic [4:0]  ld_ff, ld_in;
   logic [1:0]  lk_ff, lk_in;

   logic        rsp_valid_ff;
   logic        mv_ff, mv_in, mw_ff, mw_in;
   logic [1:0]  ms_ff, ms_in, st_ff, st_in;
   logic [31:0] ma_ff, ma_in, md_ff, md_in;
   logic [3:0]  cost_ff, cost_in;

   logic        advance, accept;
   logic        wen;
   logic [4:0]  wa;
   logic [31:0] wd;

   logic [5:0]  op;
   logic [4:0]  r1, r2;
   logic [31:0] a, b, s5, s16, d9, d26, res;
   logic [32:0] sum, shl33;
   logic [32:0] sar33;
   logic        t, cv;
   logic [4:0]  ra1, ra2;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign ra1 = req_instr_first[4:0];
   assign ra2 = req_instr_first[9:5];

   always_ff @(posedge clock) begin
      if (wen) begin
         gpr_mem[wa] <= wd;
      end
      if (accept) begin
         s1_cmd_ff <= req_cmd;
         s1_ins_ff <= req_instr_first;
         s1_ext_ff <= req_instr_second;
         s1_lv_ff  <= req_load_value;
         if (ra1 == 5'd0) s1_b_ff <= '0;
         else if (wen && wa == ra1) s1_b_ff <= wd;
         else s1_b_ff <= gpr_mem[ra1];
         if (ra2 == 5'd0) s1_a_ff <= '0;
         else if (wen && wa == ra2) s1_a_ff <= wd;
         else s1_a_ff <= gpr_mem[ra2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= PC_RESET;
         flags_ff     <= psw_flags(PSW_RESET);
         lp_ff        <= 1'b0;
         ld_ff        <= '0;
         lk_ff        <= '0;
      end else begin
         if (accept) s1_valid_ff <= 1'b1;
         else if (advance) s1_valid_ff <= 1'b0;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= pc_in;
            flags_ff     <= flags_in;
            lp_ff        <= lp_in;
            ld_ff        <= ld_in;
            lk_ff        <= lk_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         eipc_ff  <= eipc_in;
         eipsw_ff <= eipsw_in;
         fepc_ff  <= fepc_in;
         fepsw_ff <= fepsw_in;
         mv_ff    <= mv_in;
         mw_ff    <= mw_in;
         ms_ff    <= ms_in;
         ma_ff    <= ma_in;
         md_ff    <= md_in;
         cost_ff  <= cost_in;
         st_ff    <= st_in;
      end
   end

   always_comb begin
      op  = s1_ins_ff[15:10];
      r1  = s1_ins_ff[4:0];
      r2  = s1_ins_ff[9:5];
      a   = s1_a_ff;
      b   = s1_b_ff;
      s5  = {{27{r1[4]}}, r1};
      s16 = {{16{s1_ext_ff[15]}}, s1_ext_ff};
      d9  = {{23{s1_ins_ff[8]}}, s1_ins_ff[8:0]};
      d26 = {{6{s1_ins_ff[9]}}, s1_ins_ff[9:0], s1_ext_ff};
      res = '0;
      sum = '0;
      shl33 = {1'b0, a} << (op == OP_SHL ? b[4:0] : r1);
      sar33 = 33'($signed({a, 1'b0}) >>> r1);
      t   = 1'b0;
      cv  = 1'b1;

      pc_in    = pc_ff;
      flags_in = flags_ff;
      eipc_in  = eipc_ff;
      eipsw_in = eipsw_ff;
      fepc_in  = fepc_ff;
      fepsw_in = fepsw_ff;
      lp_in    = 1'b0;
      ld_in    = ld_ff;
      lk_in    = lk_ff;
      wen      = 1'b0;
      wa       = r2;
      wd       = '0;
      mv_in    = 1'b0;
      mw_in    = 1'b0;
      ms_in    = SZ_BYTE;
      ma_in    = '0;
      md_in    = '0;
      cost_in  = 4'd0;
      st_in    = ST_DONE;

      if (s1_cmd_ff) begin
         lp_in = lp_ff;
         if (!lp_ff) begin
            st_in = ST_STRAY;
         end else begin
            lp_in = 1'b0;
            wa    = ld_ff;
            wen   = advance && (ld_ff != 5'd0);
            case (lk_ff)
               SZ_BYTE: wd = {{24{s1_lv_ff[7]}}, s1_lv_ff[7:0]};
               SZ_HALF: wd = {{16{s1_lv_ff[15]}}, s1_lv_ff[15:0]};
               default: wd = s1_lv_ff;
            endcase
         end
      end else if (s1_ins_ff[15:13] == 3'b100) begin
         case (s1_ins_ff[12:9])
            CC_C:  t = flags_ff[F_CY];
            CC_Z:  t = flags_ff[F_Z];
            CC_NH: t = flags_ff[F_CY] | flags_ff[F_Z];
            CC_N:  t = flags_ff[F_S];
            CC_T:  t = 1'b1;
            CC_LT: t = flags_ff[F_S] ^ flags_ff[F_OV];
            CC_LE: t = (flags_ff[F_S] ^ flags_ff[F_OV]) | flags_ff[F_Z];
            CC_NV: t = !flags_ff[F_OV];
            CC_NC: t = !flags_ff[F_CY];
            CC_NZ: t = !flags_ff[F_Z];
            CC_H:  t = !(flags_ff[F_CY] | flags_ff[F_Z]);
            CC_P:  t = !flags_ff[F_S];
            CC_GE: t = !(flags_ff[F_S] ^ flags_ff[F_OV]);
            CC_GT: t = !((flags_ff[F_S] ^ flags_ff[F_OV]) | flags_ff[F_Z]);
            default: cv = 1'b0;
         endcase
         if (!cv) begin
            st_in = ST_INVALID;
         end else if (t) begin
            cost_in = 4'd3;
            pc_in   = (pc_ff + d9) & 32'hffff_fffe;
         end else begin
            cost_in = 4'd1;
            pc_in   = pc_ff + 32'd2;
         end
      end else if (!s1_ins_ff[15]) begin
         cost_in = 4'd1;
         pc_in   = pc_ff + 32'd2;
         case (op)
            OP_MOV: begin
               wen = 1'b1; wd = b;
            end
            OP_ADD, OP_ADDI5: begin
               sum = {1'b0, a} + {1'b0, (op == OP_ADD) ? b : s5};
               res = sum[31:0];
               wen = 1'b1; wd = res;
               flags_in[F_CY] = sum[32];
               flags_in[F_OV] = (a[31] ^ res[31]) & (sum[31] ^ ((op == OP_ADD) ? b[31] : s5[31]));
               flags_in[F_Z]  = (res == '0);
               flags_in[F_S]  = res[31];
            end
            OP_SUB, OP_CMP, OP_CMPI: begin
               sum = {1'b0, a} - {1'b0, (op == OP_CMPI) ? s5 : b};
               res = sum[31:0];
               wen = (op == OP_SUB); wd = res;
               flags_in[F_CY] = sum[32];
               flags_in[F_OV] = (a[31] ^ ((op == OP_CMPI) ? s5[31] : b[31])) & (a[31] ^ res[31]);
               flags_in[F_Z]  = (res == '0);
               flags_in[F_S]  = res[31];
            end
            OP_SHL, OP_SHLI: begin
               res = shl33[31:0];
               wen = 1'b1; wd = res;
               flags_in[F_CY] = shl33[32];
               flags_in[F_OV] = 1'b0;
               flags_in[F_Z]  = (res == '0);
               flags_in[F_S]  = res[31];
            end
            OP_SARI: begin
               res = sar33[32:1];
               wen = 1'b1; wd = res;
               flags_in[F_CY] = sar33[0];
               flags_in[F_OV] = 1'b0;
               flags_in[F_Z]  = (res == '0);
               flags_in[F_S]  = res[31];
            end
            OP_JMP: begin
               pc_in = b & 32'hffff_fffe; cost_in = 4'd3;
            end
            OP_OR, OP_AND, OP_XOR: begin
               res = (op == OP_OR) ? (a | b) : (op == OP_AND) ? (a & b) : (a ^ b);
               wen = 1'b1; wd = res;
               flags_in[F_OV] = 1'b0;
               flags_in[F_Z]  = (res == '0);
               flags_in[F_S]  = res[31];
            end
            OP_MOVI: begin
               wen = 1'b1; wd = s5;
            end
            OP_CLI: flags_in[F_ID] = 1'b0;
            OP_SEI: flags_in[F_ID] = 1'b1;
            OP_RETI: begin
               cost_in = 4'd10;
               if (flags_ff[F_NP]) begin
                  pc_in = fepc_ff; flags_in = psw_flags(fepsw_ff);
               end else begin
                  pc_in = eipc_ff; flags_in = psw_flags(eipsw_ff);
               end
            end
            OP_LDSR: begin
               case (r1)
                  SR_EIPC:  eipc_in  = a;
                  SR_EIPSW: eipsw_in = a;
                  SR_FEPC:  fepc_in  = a;
                  SR_FEPSW: fepsw_in = a;
                  SR_PSW:   flags_in = psw_flags(a);
                  default:  ;
               endcase
            end
            default: begin
               st_in = ST_INVALID; cost_in = 4'd0; pc_in = pc_ff;
            end
         endcase
         wen = wen && advance && (r2 != 5'd0);
      end else begin
         cost_in = 4'd1;
         pc_in   = pc_ff + 32'd4;
         case (op)
            OP_MOVEA: begin
               wen = 1'b1; wd = b + s16;
            end
            OP_ADDI: begin
               sum = {1'b0, b} + {1'b0, s16};
               res = sum[31:0];
               wen = 1'b1; wd = res;
               flags_in[F_CY] = sum[32];
               flags_in[F_OV] = (b[31] ^ res[31]) & (s16[31] ^ res[31]);
               flags_in[F_Z]  = (res == '0);
               flags_in[F_S]  = res[31];
            end
            OP_JR: begin
               pc_in = (pc_ff + d26) & 32'hffff_fffe; cost_in = 4'd3;
            end
            OP_JAL: begin
               wa = 5'd31; wen = 1'b1; wd = pc_ff + 32'd4;
               pc_in = (pc_ff + d26) & 32'hffff_fffe; cost_in = 4'd3;
            end
            OP_ORI: begin
               res = b | {16'h0, s1_ext_ff};
               wen = 1'b1; wd = res;
               flags_in[F_OV] = 1'b0;
               flags_in[F_Z]  = (res == '0);
               flags_in[F_S]  = res[31];
            end
            OP_ANDI: begin
               res = b & {16'h0, s1_ext_ff};
               wen = 1'b1; wd = res;
               flags_in[F_OV] = 1'b0;
               flags_in[F_Z]  = (res == '0);
               flags_in[F_S]  = 1'b0;
            end
            OP_MOVHI: begin
               wen = 1'b1; wd = b + {s1_ext_ff, 16'h0};
            end
            OP_LDB, OP_LDH, OP_LDW: begin
               mv_in = 1'b1; ma_in = b + s16; cost_in = 4'd5; st_in = ST_PENDING;
               ms_in = (op == OP_LDB) ? SZ_BYTE : (op == OP_LDH) ? SZ_HALF : SZ_WORD;
               lp_in = 1'b1; ld_in = r2; lk_in = ms_in;
            end
            OP_STB, OP_STH, OP_STW: begin
               mv_in = 1'b1; mw_in = 1'b1; ma_in = b + s16; cost_in = 4'd4;
               ms_in = (op == OP_STB) ? SZ_BYTE : (op == OP_STH) ? SZ_HALF : SZ_WORD;
               md_in = (op == OP_STB) ? {24'h0, a[7:0]} :
                       (op == OP_STH) ? {16'h0, a[15:0]} : a;
            end
            default: begin
               st_in = ST_INVALID; cost_in = 4'd0; pc_in = pc_ff;
            end
         endcase
         wen = wen && advance && (wa != 5'd0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_pc    = pc_ff;
   assign rsp_mem_valid  = mv_ff;
   assign rsp_mem_write  = mw_ff;
   assign rsp_mem_size   = ms_ff;
   assign rsp_mem_addr   = ma_ff;
   assign rsp_mem_wdata  = md_ff;
   assign rsp_cycle_cost = cost_ff;
   assign rsp_status     = st_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the integer execute core
// Directed and random instruction and load-return beats are sent through the
// request channel. An instruction-level model in this file predicts each
// response beat, and a checker compares every field. Sender gaps and receiver
// stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
   import r32x_pkg::*;

   typedef struct packed {
      logic [31:0] pc;
      logic        mv;
      logic        mw;
      logic [1:0]  ms;
      logic [31:0] ma;
      logic [31:0] md;
      logic [3:0]  cost;
      logic [1:0]  st;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [15:0] req_instr_first;
   logic [15:0] req_instr_second;
   logic [31:0] req_load_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_next_pc;
   logic        rsp_mem_valid;
   logic        rsp_mem_write;
   logic [1:0]  rsp_mem_size;
   logic [31:0] rsp_mem_addr;
   logic [31:0] rsp_mem_wdata;
   logic [3:0]  rsp_cycle_cost;
   logic [1:0]  rsp_status;

   risc32_integer_execute_core_top dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // architectural state of the model
   logic [31:0] gpr [32];
   logic [31:0] cur_pc;
   logic [5:0]  flg;
   logic [31:0] eipc, eipsw, fepc, fepsw;
   logic        ld_busy;
   logic [4:0]  ld_dst;
   logic [1:0]  ld_size;

   beat_type expected_beats[$];
   int    mismatches = 0;
   int    send_idle_pct = 0;
   int    recv_idle_pct = 0;
   int    stall_cycles = 0;

   function automatic void gpr_wr(logic [4:0] i, logic [31:0] v);
      if (i != 5'd0) gpr[i] = v;
   endfunction

   function automatic void psw_load(logic [31:0] v);
      flg = {v[15], v[12], v[3:0]};
   endfunction

   function automatic void zs_update(logic [31:0] res);
      flg[F_Z] = (res == 32'd0);
      flg[F_S] = res[31];
   endfunction

   function automatic logic [31:0] logic_op(logic [31:0] res);
      flg[F_OV] = 1'b0;
      zs_update(res);
      return res;
   endfunction

   function automatic logic [31:0] add_op(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      flg[F_CY] = sum[32];
      flg[F_OV] = (a[31] ~^ b[31]) & (a[31] ^ sum[31]);
      zs_update(sum[31:0]);
      return sum[31:0];
   endfunction

   function automatic logic [31:0] sub_op(logic [31:0] a, logic [31:0] b);
      logic [31:0] res;
      res = a - b;
      flg[F_CY] = (b > a);
      flg[F_OV] = (a[31] ^ b[31]) & (a[31] ^ res[31]);
      zs_update(res);
      return res;
   endfunction

   function automatic logic [31:0] shl_op(logic [31:0] v, logic [4:0] c);
      logic [32:0] wide;
      wide = {1'b0, v} << c;
      flg[F_CY] = (c != 5'd0) ? wide[32] : 1'b0;
      return logic_op(wide[31:0]);
   endfunction

   function automatic logic [31:0] sar_op(logic [31:0] v, logic [4:0] c);
      flg[F_CY] = (c != 5'd0) ? v[c - 5'd1] : 1'b0;
      return logic_op($signed(v) >>> c);
   endfunction

   function automatic int cond_eval(logic [3:0] cc);
      logic z, s, ov, cy;
      z = flg[F_Z]; s = flg[F_S]; ov = flg[F_OV]; cy = flg[F_CY];
      case (cc)
         CC_C:  return cy;
         CC_Z:  return z;
         CC_NH: return cy | z;
         CC_N:  return s;
         CC_T:  return 1;
         CC_LT: return s ^ ov;
         CC_LE: return (s ^ ov) | z;
         CC_NV: return !ov;
         CC_NC: return !cy;
         CC_NZ: return !z;
         CC_H:  return !(cy | z);
         CC_P:  return !s;
         CC_GE: return !(s ^ ov);
         CC_GT: return !((s ^ ov) | z);
         default: return -1;
      endcase
   endfunction

   function automatic beat_type execute_beat(logic cmd, logic [15:0] ins, logic [15:0] ext,
                                             logic [31:0] lv);
      beat_type r;
      logic [5:0]  op;
      logic [4:0]  f1, f2;
      logic [31:0] pc, a, b, s5, s16, d26, d9, v, res;
      int t;
      r = '0;
      pc = cur_pc;
      op = ins[15:10];
      f1 = ins[4:0];
      f2 = ins[9:5];
      if (cmd) begin
         if (!ld_busy) begin
            r.st = ST_STRAY;
         end else begin
            case (ld_size)
               SZ_BYTE: v = {{24{lv[7]}}, lv[7:0]};
               SZ_HALF: v = {{16{lv[15]}}, lv[15:0]};
               default: v = lv;
            endcase
            gpr_wr(ld_dst, v);
            ld_busy = 1'b0;
         end
      end else begin
         ld_busy = 1'b0;
         if (ins[15:13] == 3'b100) begin
            t = cond_eval(ins[12:9]);
            d9 = {{23{ins[8]}}, ins[8:0]};
            if (t < 0) begin
               r.st = ST_INVALID;
            end else if (t != 0) begin
               r.cost = 4'd3;
               cur_pc = (pc + d9) & 32'hffff_fffe;
            end else begin
               r.cost = 4'd1;
               cur_pc = pc + 32'd2;
            end
         end else if (op < 6'h20) begin
            a = gpr[f2];
            b = gpr[f1];
            s5 = {{27{f1[4]}}, f1};
            r.cost = 4'd1;
            cur_pc = pc + 32'd2;
            case (op)
               OP_MOV:   gpr_wr(f2, b);
               OP_ADD:   gpr_wr(f2, add_op(a, b));
               OP_SUB:   gpr_wr(f2, sub_op(a, b));
               OP_CMP:   void'(sub_op(a, b));
               OP_SHL:   gpr_wr(f2, shl_op(a, b[4:0]));
               OP_JMP: begin
                  cur_pc = b & 32'hffff_fffe;
                  r.cost = 4'd3;
               end
               OP_OR:    gpr_wr(f2, logic_op(a | b));
               OP_AND:   gpr_wr(f2, logic_op(a & b));
               OP_XOR:   gpr_wr(f2, logic_op(a ^ b));
               OP_MOVI:  gpr_wr(f2, s5);
               OP_ADDI5: gpr_wr(f2, add_op(a, s5));
               OP_CMPI:  void'(sub_op(a, s5));
               OP_SHLI:  gpr_wr(f2, shl_op(a, f1));
               OP_CLI:   flg[F_ID] = 1'b0;
               OP_SARI:  gpr_wr(f2, sar_op(a, f1));
               OP_RETI: begin
                  if (flg[F_NP]) begin
                     cur_pc = fepc;
                     psw_load(fepsw);
                  end else begin
                     cur_pc = eipc;
                     psw_load(eipsw);
                  end
                  r.cost = 4'd10;
               end
               OP_LDSR: begin
                  case (f1)
                     SR_EIPC:  eipc = a;
                     SR_EIPSW: eipsw = a;
                     SR_FEPC:  fepc = a;
                     SR_FEPSW: fepsw = a;
                     SR_PSW:   psw_load(a);
                     default: ;
                  endcase
               end
               OP_SEI:   flg[F_ID] = 1'b1;
               default: begin
                  r.st = ST_INVALID;
                  r.cost = 4'd0;
                  cur_pc = pc;
               end
            endcase
         end else begin
            b = gpr[f1];
            s16 = {{16{ext[15]}}, ext};
            d26 = {{6{ins[9]}}, ins[9:0], ext};
            r.cost = 4'd1;
            cur_pc = pc + 32'd4;
            case (op)
               OP_MOVEA: gpr_wr(f2, b + s16);
               OP_ADDI:  gpr_wr(f2, add_op(b, s16));
               OP_JR: begin
                  cur_pc = (pc + d26) & 32'hffff_fffe;
                  r.cost = 4'd3;
               end
               OP_JAL: begin
                  gpr_wr(5'd31, pc + 32'd4);
                  cur_pc = (pc + d26) & 32'hffff_fffe;
                  r.cost = 4'd3;
               end
               OP_ORI:   gpr_wr(f2, logic_op(b | {16'd0, ext}));
               OP_ANDI: begin
                  res = b & {16'd0, ext};
                  gpr_wr(f2, res);
                  flg[F_OV] = 1'b0;
                  flg[F_S] = 1'b0;
                  flg[F_Z] = (res == 32'd0);
               end
               OP_MOVHI: gpr_wr(f2, b + {ext, 16'd0});
               OP_LDB, OP_LDH, OP_LDW: begin
                  r.mv = 1'b1;
                  r.ms = (op == OP_LDW) ? SZ_WORD : op[1:0];
                  r.ma = b + s16;
                  r.cost = 4'd5;
                  r.st = ST_PENDING;
                  ld_busy = 1'b1;
                  ld_dst = f2;
                  ld_size = r.ms;
               end
               OP_STB, OP_STH, OP_STW: begin
                  r.mv = 1'b1;
                  r.mw = 1'b1;
                  r.ms = (op == OP_STW) ? SZ_WORD : op[1:0];
                  r.ma = b + s16;
                  r.cost = 4'd4;
                  r.md = gpr[f2];
                  if (r.ms == SZ_BYTE) r.md[31:8] = '0;
                  else if (r.ms == SZ_HALF) r.md[31:16] = '0;
               end
               default: begin
                  r.st = ST_INVALID;
                  r.cost = 4'd0;
                  cur_pc = pc;
               end
            endcase
         end
      end
      r.pc = cur_pc;
      return r;
   endfunction

   function automatic logic [15:0] enc(logic [5:0] op, logic [4:0] f2, logic [4:0] f1);
      return {op, f2, f1};
   endfunction

   function automatic logic [15:0] bcc(logic [3:0] cc, logic [8:0] d9);
      return {3'b100, cc, d9};
   endfunction

   task automatic send_beat(logic cmd, logic [15:0] ins, logic [15:0] ext, logic [31:0] lv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_instr_first <= ins;
      req_instr_second <= ext;
      req_load_value <= lv;
      do @(posedge clock); while (!req_ready);
      expected_beats.push_back(execute_beat(cmd, ins, ext, lv));
   endtask

   task automatic exec16(logic [15:0] ins);
      send_beat(1'b0, ins, 16'($urandom), $urandom);
   endtask

   task automatic exec32(logic [15:0] ins, logic [15:0] ext);
      send_beat(1'b0, ins, ext, $urandom);
   endtask

   task automatic load_return(logic [31:0] lv);
      send_beat(1'b1, 16'($urandom), 16'($urandom), lv);
   endtask

   task automatic set_reg(logic [4:0] i, logic [31:0] v);
      exec32(enc(OP_MOVHI, i, 5'd0), v[31:16] + {15'd0, v[15]});
      exec32(enc(OP_MOVEA, i, i), v[15:0]);
   endtask

   // registers r1 to r31 and every save register are written before anything reads them
   task automatic test_init();
      for (int i = 1; i < 32; i++) exec32(enc(OP_MOVEA, i[4:0], 5'd0), 16'($urandom));
      for (int i = 0; i < 4; i++) exec16(enc(OP_LDSR, 5'($urandom_range(31)), i[4:0]));
   endtask

   task automatic test_alu();
      set_reg(5'd1, 32'h7fff_ffff);
      exec32(enc(OP_MOVEA, 5'd2, 5'd0), 16'd1);
      exec16(enc(OP_ADD, 5'd1, 5'd2));
      exec16(enc(OP_SUB, 5'd2, 5'd1));
      exec16(enc(OP_CMP, 5'd2, 5'd2));
      exec32(enc(OP_MOVEA, 5'd3, 5'd0), 16'd33);
      exec16(enc(OP_SHL, 5'd1, 5'd3));
      exec16(enc(OP_SHLI, 5'd1, 5'd0));
      exec16(enc(OP_SARI, 5'd1, 5'd31));
      exec16(enc(OP_OR, 5'd4, 5'd1));
      exec16(enc(OP_AND, 5'd4, 5'd2));
      exec16(enc(OP_XOR, 5'd4, 5'd4));
      exec16(enc(OP_MOVI, 5'd5, 5'h10));
      exec16(enc(OP_ADDI5, 5'd5, 5'h0f));
      exec16(enc(OP_CMPI, 5'd5, 5'h1f));
      exec32(enc(OP_ADDI, 5'd6, 5'd1), 16'h8000);
      exec32(enc(OP_ORI, 5'd6, 5'd0), 16'hffff);
      exec32(enc(OP_ANDI, 5'd6, 5'd6), 16'h0000);
   endtask

   task automatic test_branch();
      exec16(bcc(4'd0, 9'd4));
      exec16(bcc(4'd13, 9'd4));
      exec16(bcc(CC_T, 9'h100));
      exec16(bcc(CC_Z, 9'h0ff));
      exec16(bcc(CC_NZ, 9'h003));
   endtask

   task automatic test_jump();
      exec16(enc(OP_JMP, 5'd0, 5'd1));
      exec32(enc(OP_JR, 5'h1f, 5'h1f), 16'hfffe);
      exec32(enc(OP_JAL, 5'h10, 5'd0), 16'h0000);
   endtask

   task automatic test_system();
      exec16(enc(OP_RETI, 5'd0, 5'd0));
      set_reg(5'd7, 32'hffff_9fff);
      exec16(enc(OP_LDSR, 5'd7, SR_PSW));
      exec16(enc(OP_LDSR, 5'd7, 5'd4));
      exec16(enc(OP_CLI, 5'd0, 5'd0));
      exec16(enc(OP_SEI, 5'd0, 5'd0));
      exec16(enc(OP_LDSR, 5'd0, SR_PSW));
      exec16(enc(OP_RETI, 5'd0, 5'd0));
   endtask

   task automatic test_memory();
      load_return($urandom);
      exec32(enc(OP_LDB, 5'd8, 5'd1), 16'h8000);
      load_return(32'hffff_ff80);
      exec32(enc(OP_LDH, 5'd9, 5'd1), 16'h7fff);
      load_return(32'h0000_8000);
      exec32(enc(OP_LDW, 5'd0, 5'd1), 16'd0);
      load_return(32'hffff_ffff);
      exec32(enc(OP_LDW, 5'd10, 5'd2), 16'd4);
      exec16(enc(OP_MOV, 5'd11, 5'd10));
      load_return(32'h1234_5678);
      exec32(enc(OP_STB, 5'd1, 5'd2), 16'hffff);
      exec32(enc(OP_STH, 5'd1, 5'd2), 16'd2);
      exec32(enc(OP_STW, 5'd1, 5'd0), 16'd0);
   endtask

   task automatic test_invalid();
      exec32(16'hfc00, 16'($urandom));
      exec16(16'h1400);
      exec32(16'hb800, 16'($urandom));
   endtask

   task automatic random_item();
      int k;
      logic [5:0] ops[31];
      ops = '{OP_MOV, OP_ADD, OP_SUB, OP_CMP, OP_SHL, OP_JMP, OP_OR, OP_AND, OP_XOR,
              OP_MOVI, OP_ADDI5, OP_CMPI, OP_SHLI, OP_CLI, OP_SARI, OP_RETI, OP_LDSR,
              OP_SEI, OP_MOVEA, OP_ADDI, OP_JR, OP_JAL, OP_ORI, OP_ANDI, OP_MOVHI,
              OP_LDB, OP_LDH, OP_LDW, OP_STB, OP_STH, OP_STW};
      k = $urandom_range(99);
      if (k < 8) begin
         exec32(16'($urandom), 16'($urandom));
      end else if (k < 12) begin
         load_return($urandom);
      end else if (k < 25) begin
         exec16(bcc(4'($urandom), 9'($urandom)));
      end else begin
         exec32({ops[$urandom_range(30)], 10'($urandom)}, 16'($urandom));
         if (ld_busy && $urandom_range(99) < 85) load_return($urandom);
      end
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) random_item();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      beat_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_next_pc, rsp_mem_valid, rsp_mem_write, rsp_mem_size, rsp_mem_addr,
                 rsp_mem_wdata, rsp_cycle_cost, rsp_status};
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat: %p", got);
         end else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch\n  expected %p\n  actual   %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= 5000) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= 1'b0;
      req_instr_first <= '0;
      req_instr_second <= '0;
      req_load_value <= '0;
      cur_pc = PC_RESET;
      flg = 6'b100000;
      ld_busy = 1'b0;
      ld_dst = '0;
      ld_size = SZ_BYTE;
      foreach (gpr[i]) gpr[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_init();
      test_alu();
      test_branch();
      test_jump();
      test_system();
      test_memory();
      test_invalid();
      test_random(300);
      send_idle_pct = 49;
      test_random(300);
      send_idle_pct = 0;
      recv_idle_pct = 49;
      test_random(300);
      send_idle_pct = 8;
      recv_idle_pct = 8;
      test_random(300);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
